@@ src/cdi_pkg.sv @@
// Package with constants, month tables and stage types for the calendar date info core.
`default_nettype none

package cdi_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 48;

  localparam int unsigned PROD_W  = 27;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned Q100_W  = 8;

  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [2:0] WD_THU = 3'd4;
  localparam logic [2:0] WD_SAT = 3'd6;
  localparam logic [2:0] WEEK_LEN = 3'd7;

  localparam logic [4:0] FEB_DAYS = 5'd28;
  localparam logic [9:0] YEAR_DAYS = 10'd365;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               month_ok;
    logic               is_feb;
    logic               is_dec;
    logic               after_feb;
    logic               y_neg;
    logic [YEAR_W-1:0]  y_shift;
    logic [PROD_W-1:0]  prod_year;
    logic [PROD_W-1:0]  prod_y;
    logic [4:0]         month_off;
    logic [8:0]         days_before;
    logic [4:0]         month_len;
  } s1_t;

  typedef struct packed {
    logic               date_valid;
    logic [SUM_W-1:0]   wd_sum;
    logic               leap_year;
    logic [4:0]         days_to_month_end;
    logic [8:0]         days_to_year_end;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
  } s2_t;

  // Floor of 31 * m / 12 for the shifted month m (March is 1, February is 12).
  function automatic logic [4:0] month_offset(input logic [MONTH_W-1:0] month);
    logic [4:0] r;
    case (month)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] r;
    case (month)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] month);
    logic [4:0] r;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      r = 5'd30;
      4'd2:                                          r = FEB_DAYS;
      default:                                       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/calendar_date_info_core.sv @@
// Top level of the calendar date info core: a three-stage pipeline from date to date facts.
//
// One date enters on the in_ stream channel as a word of day, month and year, and one
// result word leaves on the out_ channel for every accepted date, in order.
// Stage one looks up the month tables and multiplies the year and the shifted year by a
// reciprocal of 100. Stage two finds the leap year, the validity, the day counts, the
// following date and the weekday sum. Stage three reduces that sum modulo 7 and zeroes
// every field of an invalid date. The output register is the third stage.
// The accepting edge loads the first stage. Throughput is one word per cycle while out_tready
// stays high; each stage holds its own valid bit, so bubbles close up while the receiver
// stalls, and in_tready stays high as long as some stage is empty.
// When the receiver stalls with all stages full, every stage holds its word and
// in_tready falls; nothing is lost or repeated.
// Reset clears all valid bits; payload registers keep whatever they held.
`default_nettype none

module calendar_date_info_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  // Fields from bit 0: day[4:0], month[8:5], year[22:9], zero[23].
  input  wire logic [cdi_pkg::IN_W-1:0]    in_tdata,
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  // Fields from bit 0: date_valid, weekday[3:1], end_of_week, weekend, business_day,
  // leap_year, days_to_week_end[10:8], days_to_month_end[15:11],
  // days_to_year_end[24:16], next_day[29:25], next_month[33:30], next_year[47:34].
  output      logic [cdi_pkg::OUT_W-1:0]   out_tdata
);

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, out_valid_r;
  cdi_pkg::s1_t s1_r, s1_nxt;
  cdi_pkg::s2_t s2_r, s2_nxt;
  logic [cdi_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic [cdi_pkg::DAY_W-1:0]   in_day;
  logic [cdi_pkg::MONTH_W-1:0] in_month;
  logic [cdi_pkg::YEAR_W-1:0]  in_year;
  logic                        in_a;

  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[22:9];

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // Stage one: tables and reciprocal products.
  always_comb begin
    in_a               = (in_month == cdi_pkg::MON_JAN) || (in_month == cdi_pkg::MON_FEB);
    s1_nxt.day         = in_day;
    s1_nxt.month       = in_month;
    s1_nxt.year        = in_year;
    s1_nxt.month_ok    = (in_month != '0) && (in_month <= cdi_pkg::MON_DEC);
    s1_nxt.is_feb      = (in_month == cdi_pkg::MON_FEB);
    s1_nxt.is_dec      = (in_month == cdi_pkg::MON_DEC);
    s1_nxt.after_feb   = (in_month > cdi_pkg::MON_FEB);
    s1_nxt.y_neg       = in_a && (in_year == '0);
    s1_nxt.y_shift     = in_year - cdi_pkg::YEAR_W'(in_a);
    s1_nxt.prod_year   = cdi_pkg::PROD_W'(in_year) * cdi_pkg::PROD_W'(cdi_pkg::DIV100_RECIP);
    s1_nxt.prod_y      = cdi_pkg::PROD_W'(s1_nxt.y_shift) *
                         cdi_pkg::PROD_W'(cdi_pkg::DIV100_RECIP);
    s1_nxt.month_off   = cdi_pkg::month_offset(in_month);
    s1_nxt.days_before = cdi_pkg::days_before_month(in_month);
    s1_nxt.month_len   = cdi_pkg::month_length(in_month);
  end

  // Stage two: leap year, validity, counts, following date and weekday sum.
  logic [cdi_pkg::Q100_W-1:0] q_year, q_y;
  logic [cdi_pkg::YEAR_W-1:0] rem_year;
  logic                       leap;
  logic [4:0]                 dim;
  logic [9:0]                 dye_wide;
  logic                       last_day;

  always_comb begin
    q_year   = s1_r.prod_year[cdi_pkg::DIV100_SHIFT +: cdi_pkg::Q100_W];
    q_y      = s1_r.prod_y[cdi_pkg::DIV100_SHIFT +: cdi_pkg::Q100_W];
    rem_year = s1_r.year - cdi_pkg::YEAR_W'(q_year * 14'd100);
    leap     = (rem_year == '0) ? (q_year[1:0] == 2'b00) : (s1_r.year[1:0] == 2'b00);
    dim      = s1_r.is_feb ? (cdi_pkg::FEB_DAYS + 5'(leap)) : s1_r.month_len;
    last_day = (s1_r.day == dim);

    s2_nxt.date_valid = s1_r.month_ok && (s1_r.day != '0) && (s1_r.day <= dim);
    s2_nxt.leap_year  = leap;
    if (s1_r.y_neg) begin
      s2_nxt.wd_sum = cdi_pkg::SUM_W'(s1_r.day) + cdi_pkg::SUM_W'(s1_r.month_off) -
                      cdi_pkg::SUM_W'(1);
    end else begin
      s2_nxt.wd_sum = cdi_pkg::SUM_W'(s1_r.day) + cdi_pkg::SUM_W'(s1_r.y_shift) +
                      cdi_pkg::SUM_W'(s1_r.y_shift[13:2]) - cdi_pkg::SUM_W'(q_y) +
                      cdi_pkg::SUM_W'(q_y[7:2]) + cdi_pkg::SUM_W'(s1_r.month_off);
    end
    s2_nxt.days_to_month_end = dim - s1_r.day + 5'd1;
    dye_wide = cdi_pkg::YEAR_DAYS + 10'(leap) - 10'(s1_r.days_before) -
               10'(leap && s1_r.after_feb) - 10'(s1_r.day) + 10'd1;
    s2_nxt.days_to_year_end = dye_wide[8:0];
    if (last_day) begin
      s2_nxt.next_day = 5'd1;
      if (s1_r.is_dec) begin
        s2_nxt.next_month = cdi_pkg::MON_JAN;
        s2_nxt.next_year  = s1_r.year + 14'd1;
      end else begin
        s2_nxt.next_month = s1_r.month + 4'd1;
        s2_nxt.next_year  = s1_r.year;
      end
    end else begin
      s2_nxt.next_day   = s1_r.day + 5'd1;
      s2_nxt.next_month = s1_r.month;
      s2_nxt.next_year  = s1_r.year;
    end
  end

  // Stage three: modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  logic [5:0] oct_sum;
  logic [3:0] oct_fold;
  logic [2:0] wd;

  always_comb begin
    oct_sum  = 6'(s2_r.wd_sum[2:0]) + 6'(s2_r.wd_sum[5:3]) + 6'(s2_r.wd_sum[8:6]) +
               6'(s2_r.wd_sum[11:9]) + 6'(s2_r.wd_sum[14:12]);
    oct_fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    wd       = (oct_fold >= 4'(cdi_pkg::WEEK_LEN)) ? 3'(oct_fold - 4'(cdi_pkg::WEEK_LEN))
                                                   : oct_fold[2:0];
    if (s2_r.date_valid) begin
      out_data_nxt = {s2_r.next_year, s2_r.next_month, s2_r.next_day,
                      s2_r.days_to_year_end, s2_r.days_to_month_end,
                      3'(cdi_pkg::WD_SAT - wd), s2_r.leap_year,
                      (wd <= cdi_pkg::WD_THU), (wd > cdi_pkg::WD_THU),
                      (wd == cdi_pkg::WD_SAT), wd, 1'b1};
    end else begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[0]) |-> (out_data_r[cdi_pkg::OUT_W-1:1] == '0))
    else $error("invalid date produced nonzero fields");

  a_week_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |->
      ((out_data_r[3:1] <= cdi_pkg::WD_SAT) &&
       (4'(out_data_r[3:1]) + 4'(out_data_r[10:8]) == 4'(cdi_pkg::WD_SAT))))
    else $error("weekday and days to week end disagree");

  a_day_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |-> ((out_data_r[5] != out_data_r[6]) &&
                                        (out_data_r[29:25] != '0)))
    else $error("weekend and business day flags or next day wrong");

  a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && rdy1) |=> v1_r)
    else $error("accepted word not captured in first stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(s2_r)))
    else $error("second stage changed while stalled");

endmodule

`default_nettype wire

@@ tb/sv/calendar_date_checker.sv @@
`timescale 1ns / 1ps
// Checker for the calendar date info core: predicts each result word from the accepted date and compares it.
module calendar_date_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [cdi_pkg::IN_W-1:0]   in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [cdi_pkg::OUT_W-1:0]  out_tdata,
  output int                         mismatches,
  output int                         pending,
  output int                         checked,
  output int                         valid_dates,
  output logic [6:0]                 weekdays_seen
);
  import cdi_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [YEAR_W-1:0]  next_year;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   next_day;
    logic [8:0]         days_to_year_end;
    logic [4:0]         days_to_month_end;
    logic [2:0]         days_to_week_end;
    logic               leap_year;
    logic               business_day;
    logic               weekend;
    logic               end_of_week;
    logic [2:0]         weekday;
    logic               date_valid;
  } date_facts_t;

  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    date_facts_t        facts;
  } awaited_date_t;

  awaited_date_t awaited_dates[$];
  awaited_date_t entry;
  date_facts_t   result;

  initial begin
    mismatches    = 0;
    pending       = 0;
    checked       = 0;
    valid_dates   = 0;
    weekdays_seen = '0;
  end

  function automatic int month_len_of(input int month, input bit leap);
    if (month == MON_FEB) return leap ? 29 : 28;
    if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
    return 31;
  endfunction

  function automatic date_facts_t date_facts(input logic [DAY_W-1:0] day,
                                             input logic [MONTH_W-1:0] month,
                                             input logic [YEAR_W-1:0] year);
    date_facts_t f;
    int d, mo, yr, dim, shift, y, m, s, wd, doy;
    bit leap;
    f     = '0;
    d     = int'(day);
    mo    = int'(month);
    yr    = int'(year);
    leap  = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    if (mo < 1 || mo > 12) return f;
    dim = month_len_of(mo, leap);
    if (d < 1 || d > dim) return f;

    // January and February count as months 11 and 12 of the year before.
    shift = (mo <= MON_FEB) ? 1 : 0;
    y     = yr - shift;
    m     = mo + 12 * shift - 2;
    s     = d + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12;
    wd    = s % 7;

    doy = d;
    for (int k = 1; k < mo; k++) doy += month_len_of(k, leap);

    f.date_valid        = 1'b1;
    f.weekday           = wd[2:0];
    f.end_of_week       = (wd == WD_SAT);
    f.weekend           = (wd > WD_THU);
    f.business_day      = (wd <= WD_THU);
    f.leap_year         = leap;
    f.days_to_week_end  = 3'(6 - wd);
    f.days_to_month_end = 5'(dim - d + 1);
    f.days_to_year_end  = 9'((leap ? 366 : 365) - doy + 1);
    if (d == dim) begin
      f.next_day = 5'd1;
      if (mo == MON_DEC) begin
        f.next_month = 4'd1;
        f.next_year  = year + 1'b1;
      end else begin
        f.next_month = month + 1'b1;
        f.next_year  = year;
      end
    end else begin
      f.next_day   = day + 1'b1;
      f.next_month = month;
      f.next_year  = year;
    end
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input awaited_date_t e, input string field,
                               input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("date %0d/%0d/%0d %s: got %0d, expected %0d",
                                e.day, e.month, e.year, field, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        entry.day   = in_tdata[DAY_W-1:0];
        entry.month = in_tdata[DAY_W +: MONTH_W];
        entry.year  = in_tdata[DAY_W+MONTH_W +: YEAR_W];
        entry.facts = date_facts(entry.day, entry.month, entry.year);
        awaited_dates.push_back(entry);
      end
      if (out_tvalid && out_tready) begin
        result = date_facts_t'(out_tdata);
        if (awaited_dates.size() == 0) begin
          report_mismatch($sformatf("result word %h arrived with no date waiting", out_tdata));
        end else begin
          entry = awaited_dates.pop_front();
          compare_field(entry, "date_valid", result.date_valid, entry.facts.date_valid);
          compare_field(entry, "weekday", result.weekday, entry.facts.weekday);
          compare_field(entry, "end_of_week", result.end_of_week, entry.facts.end_of_week);
          compare_field(entry, "weekend", result.weekend, entry.facts.weekend);
          compare_field(entry, "business_day", result.business_day, entry.facts.business_day);
          compare_field(entry, "leap_year", result.leap_year, entry.facts.leap_year);
          compare_field(entry, "days_to_week_end", result.days_to_week_end,
                        entry.facts.days_to_week_end);
          compare_field(entry, "days_to_month_end", result.days_to_month_end,
                        entry.facts.days_to_month_end);
          compare_field(entry, "days_to_year_end", result.days_to_year_end,
                        entry.facts.days_to_year_end);
          compare_field(entry, "next_day", result.next_day, entry.facts.next_day);
          compare_field(entry, "next_month", result.next_month, entry.facts.next_month);
          compare_field(entry, "next_year", result.next_year, entry.facts.next_year);
          checked++;
          if (entry.facts.date_valid) begin
            valid_dates++;
            weekdays_seen[entry.facts.weekday] = 1'b1;
          end
        end
      end
      pending = awaited_dates.size();
    end
  end

endmodule

@@ tb/sv/calendar_date_info_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the calendar date info core: clock, reset, date stimulus, flow control and verdict.
module calendar_date_info_core_tb;
  import cdi_pkg::*;

  localparam int RANDOM_DATES = 1200;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 5000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  int         mismatches, pending, checked, valid_dates;
  logic [6:0] weekdays_seen;

  int dates_sent = 0;
  bit flood      = 1'b0;
  bit quiet      = 1'b0;
  int hold_count;
  int drain_cycles;
  int pick, day, month, year;

  always #5 clk = ~clk;

  calendar_date_info_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  calendar_date_checker date_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked       (checked),
    .valid_dates   (valid_dates),
    .weekdays_seen (weekdays_seen)
  );

  function automatic int month_days(input int mon, input int yr);
    if (mon == MON_FEB)
      return ((yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0))) ? 29 : 28;
    if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
    return 31;
  endfunction

  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic send_date(input int d, input int mon, input int yr);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, YEAR_W'(yr), MONTH_W'(mon), DAY_W'(d)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    dates_sent++;
    if (!flood && !quiet && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 17));
  endtask

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (dates_sent >= HOLD_AT && hold_count == 0) begin
        // Long hold-off while the sender keeps offering, so the pipeline fills up.
        flood      = 1'b1;
        out_tready <= 1'b0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        flood      = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    hold_count = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_date(1, 1, 1);
    send_date(31, 12, 9999);
    send_date(31, 12, 16383);
    send_date(29, 2, 2000);
    send_date(29, 2, 1900);
    send_date(28, 2, 1900);
    send_date(29, 2, 2024);
    send_date(29, 2, 2023);
    send_date(0, 5, 2020);
    send_date(1, 0, 2020);
    send_date(1, 13, 2020);
    send_date(31, 15, 16383);
    send_date(31, 4, 2021);
    send_date(30, 4, 2021);
    send_date(1, 1, 0);
    send_date(29, 2, 0);
    send_date(1, 3, 0);
    send_date(31, 1, 2024);
    send_date(28, 2, 2023);
    send_date(31, 12, 10000);
    send_date(15, 6, 1970);
    send_date(1, 1, 16383);
    send_date(30, 11, 8191);
    send_date(1, 1, 2000);

    for (int i = 0; i < RANDOM_DATES; i++) begin
      if (i >= RANDOM_DATES - QUIET_TAIL) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        year  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
        month = $urandom_range(1, 12);
        day   = ($urandom_range(0, 3) == 0) ? month_days(month, year)
                                            : $urandom_range(1, month_days(month, year));
      end else if (pick < 82) begin
        // Century and leap boundaries at the end of February and of the year.
        year  = $urandom_range(0, 163) * 100 + $urandom_range(0, 1) * $urandom_range(0, 3);
        month = $urandom_range(0, 1) ? MON_FEB : MON_DEC;
        day   = (month == MON_FEB) ? 28 + $urandom_range(0, 1) : 31;
      end else begin
        day   = $urandom_range(0, 31);
        month = $urandom_range(0, 15);
        year  = $urandom_range(0, 16383);
      end
      send_date(day, month, year);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    drain_cycles = 0;
    while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(negedge clk);

    $display("Sent %0d dates; %0d result words checked, %0d valid dates and %0d rejected.",
             dates_sent, checked, valid_dates, checked - valid_dates);
    $display("Weekdays covered %b; output held off %0d cycles with the input stalled.",
             weekdays_seen, hold_count);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cdi_pkg.sv
src/calendar_date_info_core.sv
tb/sv/calendar_date_checker.sv
tb/sv/calendar_date_info_core_tb.sv
